// File: sv/oms_pkg.sv
// Shared types and constants for the opportunity-model similarity block.
// No dependencies; imported by every module of the block except oms_ram.
package oms_pkg;

	localparam int LOC_W      = 7;   // location count register
	localparam int IDX_W      = 6;   // row and col fields
	localparam int DATA_W     = 32;  // stored distances, flows, populations
	localparam int SUM_W      = 38;  // opportunity, outflow and total sums (wrap)
	localparam int Q31_W      = 32;  // Q1.31 exponential values
	localparam int RATIO_W    = 33;  // Q1.32 ratio, may hold exactly 1.0
	localparam int PHI_W      = 39;  // high outflow part times ratio
	localparam int PLO_W      = 65;  // low outflow part times ratio
	localparam int PRED_W     = 40;  // predicted flow
	localparam int FSUM_W     = 41;  // predicted plus observed flow
	localparam int PAIR_W     = 2 * LOC_W;
	localparam int MEAN_W     = 17;
	localparam int DEGEN_W    = 12;
	localparam int SIM_W      = PAIR_W + MEAN_W;
	localparam int SIM_SHIFT  = 17;
	localparam int DIV_NUM_W  = 64;
	localparam int DIV_DEN_W  = 41;
	localparam int DIV_CNT_W  = 6;
	localparam int TAYLOR_TERMS = 6;
	localparam int SQUARINGS  = 8;

	localparam logic [Q31_W-1:0]   Q31_ONE    = 32'h8000_0000;
	localparam logic [63:0]        EXP_CUTOFF = 64'd23 << 32;
	localparam logic [63:0]        SQ_ROUND   = 64'd1 << 30;
	localparam logic [RATIO_W-1:0] RATIO_ONE  = 33'h1_0000_0000;

	typedef enum logic [1:0] {
		OP_LOAD_DIST = 2'd0,
		OP_LOAD_FLOW = 2'd1,
		OP_LOAD_POP  = 2'd2,
		OP_RUN       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_TOT,
		ACC_OUT,
		ACC_OPP
	} acc_t;

	typedef enum logic [1:0] {
		EXP_SEL_TOTAL,
		EXP_SEL_SHIFTED,
		EXP_SEL_FULL
	} exp_sel_t;

	typedef enum logic [1:0] {
		DIV_SEL_RATIO,
		DIV_SEL_SIM,
		DIV_SEL_MEAN
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TOT,
		ST_TOT_W,
		ST_DEN,
		ST_DEN_W,
		ST_ROW,
		ST_OUT,
		ST_OUT_W,
		ST_PAIR,
		ST_PAIR_W,
		ST_OPP,
		ST_OPP_W,
		ST_E1,
		ST_E1_W,
		ST_E2,
		ST_E2_W,
		ST_RATIO,
		ST_RATIO_W,
		ST_PRED,
		ST_PRED_SUM,
		ST_SIM,
		ST_SIM_W,
		ST_NEXT,
		ST_MEAN,
		ST_MEAN_W,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [2:0] {
		EXP_IDLE,
		EXP_MUL,
		EXP_ARG,
		EXP_TMUL,
		EXP_TDIV,
		EXP_SQR,
		EXP_DONE
	} exp_state_t;

	typedef struct packed {
		logic     accept;
		logic     run_start;
		logic     k_step;
		logic     j_step;
		logic     i_step;
		logic     addr_pair;
		acc_t     acc;
		logic     o_clear;
		logic     pair_capture;
		logic     exp_start;
		exp_sel_t exp_sel;
		logic     denom_capture;
		logic     e1_capture;
		logic     e2_capture;
		logic     ratio_full;
		logic     ratio_capture;
		logic     div_start;
		div_sel_t div_sel;
		logic     pred_mul;
		logic     pred_sum;
		logic     pred_zero;
		logic     degen_inc;
		logic     sim_capture;
		logic     result_load;
	} dp_cmd_t;

	typedef struct packed {
		logic k_last;
		logic j_last;
		logic i_last;
		logic j_is_i;
		logic denom_zero;
		logic ratio_sat;
		logic sum_zero;
		logic exp_done;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// Reciprocals floor(2^32/k)+1 for the Taylor term divisors; exact for terms below 2^28
	function automatic logic [31:0] taylor_recip(input logic [2:0] k);
		logic [31:0] r;
		case (k)
			3'd2:    r = 32'h8000_0001;
			3'd3:    r = 32'h5555_5556;
			3'd4:    r = 32'h4000_0001;
			3'd5:    r = 32'h3333_3334;
			3'd6:    r = 32'h2AAA_AAAB;
			default: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage

// File: sv/opportunity_model_similarity.sv
// Intervening-opportunities flow model scored by the mean Sorensen index (top level).
// Loads are taken while idle and give no result. A run's length is set by the per-pair
// opportunity sweep and by two exponentials and two divisions per pair; it is shorter when an
// exponential hits its cutoff or a pair sums to zero. One run is in flight at a time.
// Asynchronous active-low reset: count 2, controller idle, no result pending; stores undefined.
// Depends on oms_pkg, oms_ctrl and oms_dp.
module opportunity_model_similarity import oms_pkg::*; #(
	parameter int MAX_LOCATIONS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LOC_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [IDX_W-1:0]   row,
	input  logic [IDX_W-1:0]   col,
	input  logic [DATA_W-1:0]  value,
	input  logic [DATA_W-1:0]  alpha,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [MEAN_W-1:0]  mean_similarity,
	output logic [DEGEN_W-1:0] degenerate_pairs
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	oms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	oms_dp #(.MAX_LOCATIONS(MAX_LOCATIONS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.row              (row),
		.col              (col),
		.value            (value),
		.alpha            (alpha),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.stat             (stat),
		.out_valid        (out_valid),
		.mean_similarity  (mean_similarity),
		.degenerate_pairs (degenerate_pairs)
	);

endmodule

// File: sv/oms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/oms_exp.sv
// Iterative exp(-alpha*x*2^-40) in Q1.31: argument product, Taylor series, squarings.
// Depends on oms_pkg.
module oms_exp import oms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DATA_W-1:0]  alpha,
	input  logic [SUM_W-1:0]   x,
	output logic               done,
	output logic [Q31_W-1:0]   result
);

	exp_state_t       state_q, state_d;
	logic [SUM_W-1:0] x_q;
	logic [37:0]      ph_q;
	logic [63:0]      pl_q;
	logic [63:0]      t;
	logic             cutoff;
	logic [31:0]      y_q;
	logic [31:0]      term_q;
	logic [Q31_W-1:0] sum_q;
	logic [63:0]      prod_q;
	logic [31:0]      tx;
	logic [63:0]      qprod;
	logic [31:0]      new_term;
	logic [63:0]      sq;
	logic [2:0]       k_q;
	logic [2:0]       sq_q;

	// argument in Q.32 and series helpers
	assign t        = (64'(ph_q) << 24) + (pl_q >> 8);
	assign cutoff   = (t >= EXP_CUTOFF);
	assign tx       = prod_q[62:31];
	assign qprod    = 64'(tx) * 64'(taylor_recip(k_q));
	assign new_term = (k_q == 3'd1) ? tx : qprod[63:32];
	assign sq       = 64'(sum_q) * 64'(sum_q) + SQ_ROUND;
	assign result   = sum_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EXP_IDLE: if (start) state_d = EXP_MUL;
			EXP_MUL:  state_d = EXP_ARG;
			EXP_ARG:  state_d = cutoff ? EXP_DONE : EXP_TMUL;
			EXP_TMUL: state_d = EXP_TDIV;
			EXP_TDIV: state_d = (k_q == 3'(TAYLOR_TERMS)) ? EXP_SQR : EXP_TMUL;
			EXP_SQR:  state_d = (sq_q == 3'(SQUARINGS - 1)) ? EXP_DONE : EXP_SQR;
			EXP_DONE: state_d = EXP_IDLE;
			default:  state_d = EXP_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == EXP_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EXP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			EXP_IDLE: begin
				if (start) x_q <= x;
			end
			EXP_MUL: begin
				ph_q <= alpha * x_q[37:32];
				pl_q <= alpha * x_q[31:0];
			end
			EXP_ARG: begin
				if (cutoff) begin
					sum_q <= '0;
				end else begin
					y_q    <= t[40:9];
					term_q <= Q31_ONE;
					sum_q  <= Q31_ONE;
					k_q    <= 3'd1;
				end
			end
			EXP_TMUL: begin
				prod_q <= 64'(term_q) * 64'(y_q);
			end
			EXP_TDIV: begin
				term_q <= new_term;
				sum_q  <= k_q[0] ? sum_q - new_term : sum_q + new_term;
				k_q    <= k_q + 3'd1;
				sq_q   <= '0;
			end
			EXP_SQR: begin
				sum_q <= sq[62:31];
				sq_q  <= sq_q + 3'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/oms_div.sv
// Restoring divider, one quotient bit per cycle over the full numerator width.
// Depends on oms_pkg.
module oms_div import oms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] qn_q;
	logic [DIV_DEN_W:0]   r2;
	logic                 ge;

	// trial subtract
	assign r2   = {rem_q, qn_q[DIV_NUM_W-1]};
	assign ge   = (r2 >= {1'b0, den_q});
	assign done = done_q;
	assign quot = qn_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {DIV_CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and shifting numerator/quotient
	always_ff @(posedge clk) begin
		if (start) begin
			qn_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
			qn_q  <= {qn_q[DIV_NUM_W-2:0], ge};
		end
	end

endmodule

// File: sv/oms_dp.sv
// Datapath: matrix and population stores, sweep counters, accumulators, exp and divide units.
// Depends on oms_pkg, oms_ram, oms_exp and oms_div.
module oms_dp import oms_pkg::*; #(
	parameter int MAX_LOCATIONS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LOC_W-1:0]   cfg_data,
	input  logic [1:0]         operation,
	input  logic [IDX_W-1:0]   row,
	input  logic [IDX_W-1:0]   col,
	input  logic [DATA_W-1:0]  value,
	input  logic [DATA_W-1:0]  alpha,
	input  logic               out_stall,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	output logic               out_valid,
	output logic [MEAN_W-1:0]  mean_similarity,
	output logic [DEGEN_W-1:0] degenerate_pairs
);

	localparam int IW = $clog2(MAX_LOCATIONS);
	localparam int AW = $clog2(MAX_LOCATIONS * MAX_LOCATIONS);

	logic [LOC_W-1:0]     n_q;
	logic [IW-1:0]        n_last;
	logic [PAIR_W-1:0]    pairs;
	logic [DATA_W-1:0]    alpha_q;
	logic [IW-1:0]        i_q, j_q, k_q;
	logic [IW-1:0]        cidx;
	logic [AW-1:0]        mat_raddr, mat_waddr;
	logic [IW-1:0]        pop_waddr;
	logic                 mat_in_range, pop_in_range;
	logic                 dist_we, flow_we, pop_we;
	logic [DATA_W-1:0]    dist_rdata, flow_rdata, pop_rdata;
	acc_t                 acc_s1;
	logic [IW-1:0]        kidx_s1;
	logic [SUM_W-1:0]     tot_q, o_q, s_q;
	logic [DATA_W-1:0]    dij_q, obs_q, popj_q;
	logic [Q31_W-1:0]     denom_q, e1_q, e2_q, diff;
	logic [RATIO_W-1:0]   ratio_q;
	logic [PHI_W-1:0]     ph_q;
	logic [PLO_W-1:0]     pl_q;
	logic [PRED_W-1:0]    pred_q, lo;
	logic [FSUM_W-1:0]    fsum;
	logic [SIM_W-1:0]     sim_q;
	logic [DEGEN_W-1:0]   degen_q;
	logic [SUM_W-1:0]     exp_x;
	logic                 exp_done;
	logic [Q31_W-1:0]     exp_result;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_done;
	logic                 out_valid_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [DEGEN_W-1:0]   degen_out_q;

	// load decode
	assign mat_in_range = (32'(row) < MAX_LOCATIONS) && (32'(col) < MAX_LOCATIONS);
	assign pop_in_range = (32'(row) < MAX_LOCATIONS);
	assign mat_waddr    = AW'(32'(row) * MAX_LOCATIONS + 32'(col));
	assign pop_waddr    = IW'(row);
	assign dist_we = cmd.accept && (operation == OP_LOAD_DIST) && mat_in_range;
	assign flow_we = cmd.accept && (operation == OP_LOAD_FLOW) && mat_in_range;
	assign pop_we  = cmd.accept && (operation == OP_LOAD_POP) && pop_in_range;

	// run read addresses: column from the pair counter or the sweep counter
	assign cidx      = cmd.addr_pair ? j_q : k_q;
	assign mat_raddr = AW'(32'(i_q) * MAX_LOCATIONS + 32'(cidx));

	oms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LOCATIONS * MAX_LOCATIONS)) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (mat_waddr),
		.wdata (value),
		.raddr (mat_raddr),
		.rdata (dist_rdata)
	);

	oms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LOCATIONS * MAX_LOCATIONS)) u_flow_ram (
		.clk   (clk),
		.we    (flow_we),
		.waddr (mat_waddr),
		.wdata (value),
		.raddr (mat_raddr),
		.rdata (flow_rdata)
	);

	oms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LOCATIONS)) u_pop_ram (
		.clk   (clk),
		.we    (pop_we),
		.waddr (pop_waddr),
		.wdata (value),
		.raddr (cidx),
		.rdata (pop_rdata)
	);

	// derived values
	assign n_last = IW'(n_q - LOC_W'(1));
	assign pairs  = PAIR_W'(n_q) * PAIR_W'(n_q - LOC_W'(1));
	assign diff   = (e1_q > e2_q) ? e1_q - e2_q : '0;
	assign fsum   = FSUM_W'(pred_q) + FSUM_W'(obs_q);
	assign lo     = (pred_q < PRED_W'(obs_q)) ? pred_q : PRED_W'(obs_q);

	// exponential argument select
	always_comb begin
		case (cmd.exp_sel)
			EXP_SEL_SHIFTED: exp_x = SUM_W'(s_q - SUM_W'(popj_q));
			EXP_SEL_FULL:    exp_x = s_q;
			default:         exp_x = tot_q;
		endcase
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_SEL_SIM: begin
				div_num = DIV_NUM_W'({lo, {SIM_SHIFT{1'b0}}});
				div_den = fsum;
			end
			DIV_SEL_MEAN: begin
				div_num = DIV_NUM_W'(sim_q);
				div_den = DIV_DEN_W'(pairs);
			end
			default: begin
				div_num = {diff, 32'b0};
				div_den = DIV_DEN_W'(denom_q);
			end
		endcase
	end

	oms_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exp_start),
		.alpha  (alpha_q),
		.x      (exp_x),
		.done   (exp_done),
		.result (exp_result)
	);

	oms_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// status to the controller
	always_comb begin
		stat.k_last     = (k_q == n_last);
		stat.j_last     = (j_q == n_last);
		stat.i_last     = (i_q == n_last);
		stat.j_is_i     = (j_q == i_q);
		stat.denom_zero = (denom_q == '0);
		stat.ratio_sat  = (diff >= denom_q);
		stat.sum_zero   = (fsum == '0);
		stat.exp_done   = exp_done;
		stat.div_done   = div_done;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// location count register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= LOC_W'(2);
		end else if (cfg_we) begin
			if (cfg_data < LOC_W'(2)) begin
				n_q <= LOC_W'(2);
			end else if (32'(cfg_data) > MAX_LOCATIONS) begin
				n_q <= LOC_W'(MAX_LOCATIONS);
			end else begin
				n_q <= cfg_data;
			end
		end
	end

	// sweep counters, read-tag stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			acc_s1      <= ACC_NONE;
			out_valid_q <= 1'b0;
		end else begin
			acc_s1 <= cmd.acc;
			if (cmd.run_start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else begin
				if (cmd.k_step) k_q <= (k_q == n_last) ? '0 : k_q + 1'b1;
				if (cmd.j_step) j_q <= (j_q == n_last) ? '0 : j_q + 1'b1;
				if (cmd.i_step) i_q <= (i_q == n_last) ? '0 : i_q + 1'b1;
			end
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accumulators and working registers
	always_ff @(posedge clk) begin
		kidx_s1 <= k_q;
		if (cmd.run_start) begin
			alpha_q <= alpha;
			tot_q   <= '0;
			sim_q   <= '0;
			degen_q <= '0;
		end
		case (acc_s1)
			ACC_TOT: tot_q <= tot_q + SUM_W'(pop_rdata);
			ACC_OUT: if (kidx_s1 != i_q) o_q <= o_q + SUM_W'(flow_rdata);
			ACC_OPP: if (dist_rdata <= dij_q) s_q <= s_q + SUM_W'(pop_rdata);
			default: begin
			end
		endcase
		if (cmd.o_clear) o_q <= '0;
		if (cmd.pair_capture) begin
			dij_q  <= dist_rdata;
			obs_q  <= flow_rdata;
			popj_q <= pop_rdata;
			s_q    <= '0;
		end
		if (cmd.denom_capture) denom_q <= Q31_ONE - exp_result;
		if (cmd.e1_capture) e1_q <= exp_result;
		if (cmd.e2_capture) e2_q <= exp_result;
		if (cmd.ratio_full) ratio_q <= RATIO_ONE;
		if (cmd.ratio_capture) ratio_q <= RATIO_W'(div_quot[31:0]);
		if (cmd.pred_mul) begin
			ph_q <= PHI_W'(o_q[SUM_W-1:32]) * PHI_W'(ratio_q);
			pl_q <= PLO_W'(o_q[31:0]) * PLO_W'(ratio_q);
		end
		if (cmd.pred_sum) pred_q <= PRED_W'(ph_q) + PRED_W'(pl_q[PLO_W-1:32]);
		if (cmd.pred_zero) pred_q <= '0;
		if (cmd.degen_inc) degen_q <= degen_q + 1'b1;
		if (cmd.sim_capture) sim_q <= sim_q + SIM_W'(div_quot[MEAN_W-1:0]);
		if (cmd.result_load) begin
			mean_q      <= div_quot[MEAN_W-1:0];
			degen_out_q <= degen_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign mean_similarity  = mean_q;
	assign degenerate_pairs = degen_out_q;

endmodule

// File: sv/oms_ctrl.sv
// Run sequencer: walks total, outflow, opportunity sweeps and per-pair scoring.
// Depends on oms_pkg.
module oms_ctrl import oms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] operation,
	input  dp_stat_t   stat,
	output logic       in_stall,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid && (operation == OP_RUN)) state_d = ST_TOT;
			ST_TOT:      if (stat.k_last) state_d = ST_TOT_W;
			ST_TOT_W:    state_d = ST_DEN;
			ST_DEN:      state_d = ST_DEN_W;
			ST_DEN_W:    if (stat.exp_done) state_d = ST_ROW;
			ST_ROW:      state_d = ST_OUT;
			ST_OUT:      if (stat.k_last) state_d = ST_OUT_W;
			ST_OUT_W:    state_d = ST_PAIR;
			ST_PAIR:     state_d = stat.j_is_i ? ST_NEXT : ST_PAIR_W;
			ST_PAIR_W:   state_d = ST_OPP;
			ST_OPP:      if (stat.k_last) state_d = ST_OPP_W;
			ST_OPP_W:    state_d = stat.denom_zero ? ST_SIM : ST_E1;
			ST_E1:       state_d = ST_E1_W;
			ST_E1_W:     if (stat.exp_done) state_d = ST_E2;
			ST_E2:       state_d = ST_E2_W;
			ST_E2_W:     if (stat.exp_done) state_d = ST_RATIO;
			ST_RATIO:    state_d = stat.ratio_sat ? ST_PRED : ST_RATIO_W;
			ST_RATIO_W:  if (stat.div_done) state_d = ST_PRED;
			ST_PRED:     state_d = ST_PRED_SUM;
			ST_PRED_SUM: state_d = ST_SIM;
			ST_SIM:      state_d = stat.sum_zero ? ST_NEXT : ST_SIM_W;
			ST_SIM_W:    if (stat.div_done) state_d = ST_NEXT;
			ST_NEXT: begin
				if (!stat.j_last) begin
					state_d = ST_PAIR;
				end else if (stat.i_last) begin
					state_d = ST_MEAN;
				end else begin
					state_d = ST_ROW;
				end
			end
			ST_MEAN:     state_d = ST_MEAN_W;
			ST_MEAN_W:   if (stat.div_done) state_d = ST_DONE;
			ST_DONE:     if (stat.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.accept    = in_valid;
				cmd.run_start = in_valid && (operation == OP_RUN);
			end
			ST_TOT: begin
				cmd.acc    = ACC_TOT;
				cmd.k_step = 1'b1;
			end
			ST_DEN: begin
				cmd.exp_start = 1'b1;
				cmd.exp_sel   = EXP_SEL_TOTAL;
			end
			ST_DEN_W: begin
				cmd.denom_capture = stat.exp_done;
			end
			ST_ROW: begin
				cmd.o_clear = 1'b1;
			end
			ST_OUT: begin
				cmd.acc    = ACC_OUT;
				cmd.k_step = 1'b1;
			end
			ST_PAIR: begin
				cmd.addr_pair = 1'b1;
			end
			ST_PAIR_W: begin
				cmd.pair_capture = 1'b1;
			end
			ST_OPP: begin
				cmd.acc    = ACC_OPP;
				cmd.k_step = 1'b1;
			end
			ST_OPP_W: begin
				cmd.pred_zero = stat.denom_zero;
			end
			ST_E1: begin
				cmd.exp_start = 1'b1;
				cmd.exp_sel   = EXP_SEL_SHIFTED;
			end
			ST_E1_W: begin
				cmd.e1_capture = stat.exp_done;
			end
			ST_E2: begin
				cmd.exp_start = 1'b1;
				cmd.exp_sel   = EXP_SEL_FULL;
			end
			ST_E2_W: begin
				cmd.e2_capture = stat.exp_done;
			end
			ST_RATIO: begin
				cmd.ratio_full = stat.ratio_sat;
				cmd.div_start  = !stat.ratio_sat;
				cmd.div_sel    = DIV_SEL_RATIO;
			end
			ST_RATIO_W: begin
				cmd.ratio_capture = stat.div_done;
			end
			ST_PRED: begin
				cmd.pred_mul = 1'b1;
			end
			ST_PRED_SUM: begin
				cmd.pred_sum = 1'b1;
			end
			ST_SIM: begin
				cmd.degen_inc = stat.sum_zero;
				cmd.div_start = !stat.sum_zero;
				cmd.div_sel   = DIV_SEL_SIM;
			end
			ST_SIM_W: begin
				cmd.sim_capture = stat.div_done;
			end
			ST_NEXT: begin
				cmd.j_step = 1'b1;
				cmd.i_step = stat.j_last;
			end
			ST_MEAN: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_MEAN;
			end
			ST_DONE: begin
				cmd.result_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
